### hw/rtl/tbb_pkg.sv
// Shared types and constants for the transformed box bounds block.
// Used by every module of the block; depends on nothing.
package tbb_pkg;

    localparam int COORD_W     = 32;
    localparam int CFG_W       = 64;
    localparam int NUM_CFG     = 8;
    localparam int CFG_IDX_W   = 4;
    localparam int ROW_W       = 64;
    localparam int NUM_CORNERS = 8;
    localparam int NUM_AXES    = 3;
    localparam int NUM_ROWS    = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW0_LO = 4'd0,
        CFG_ROW0_HI = 4'd1,
        CFG_ROW1_LO = 4'd2,
        CFG_ROW1_HI = 4'd3,
        CFG_ROW2_LO = 4'd4,
        CFG_ROW2_HI = 4'd5,
        CFG_ROW3_LO = 4'd6,
        CFG_ROW3_HI = 4'd7
    } cfg_reg_e;

    typedef logic [CFG_W-1:0] cfg_word_t;

    localparam cfg_word_t CFG_RESET [NUM_CFG] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef logic [NUM_ROWS-1:0][NUM_ROWS-1:0][COORD_W-1:0] matrix_t;
    typedef logic [NUM_CORNERS-1:0][NUM_ROWS-1:0][ROW_W-1:0] rows_t;
    typedef logic [NUM_CORNERS-1:0][NUM_AXES-1:0][COORD_W-1:0] points_t;

    typedef struct packed {
        coord_t             local_min_x;
        coord_t             local_min_y;
        coord_t             local_min_z;
        coord_t             local_max_x;
        coord_t             local_max_y;
        coord_t             local_max_z;
        logic [COORD_W-1:0] index_total;
        logic [COORD_W-1:0] vertex_total;
    } box_t;

    typedef struct packed {
        coord_t world_min_x;
        coord_t world_min_y;
        coord_t world_min_z;
        coord_t world_max_x;
        coord_t world_max_y;
        coord_t world_max_z;
        coord_t center_x;
        coord_t center_y;
        coord_t center_z;
    } bounds_t;

endpackage

### hw/rtl/tbb_if.sv
// Valid/ready channel carrying one payload item per transfer.
// Payload type is set per instance; no package dependency.
interface tbb_if #(parameter type T = logic);

    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

### hw/rtl/tbb_xform.sv
// Box mirroring and matrix transform of the eight corners, three stages.
// Depends on tbb_pkg and tbb_if.
module tbb_xform #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tbb_pkg::matrix_t  matrix,
    tbb_if.sink               boxes,
    tbb_if.source             rows
);

    localparam int NST = 3;
    localparam int CW  = tbb_pkg::COORD_W + 1;
    localparam int PW  = tbb_pkg::COORD_W + CW;
    localparam int SW  = PW + 2;
    localparam int RWD = tbb_pkg::ROW_W;

    logic [NST-1:0] v_reg;
    logic [NST:0]   adv;
    logic           keep;

    logic signed [CW-1:0] crd_reg  [3][2];
    logic signed [CW-1:0] crd_next [3][2];
    logic signed [PW-1:0] prod_reg  [tbb_pkg::NUM_ROWS][3][2];
    logic signed [PW-1:0] prod_next [tbb_pkg::NUM_ROWS][3][2];
    tbb_pkg::rows_t       row_reg;
    tbb_pkg::rows_t       row_next;

    always_comb
    begin
        adv[NST] = rows.ready;
        for (int s = NST - 1; s >= 0; s--)
        begin
            adv[s] = !v_reg[s] || adv[s+1];
        end
    end

    assign boxes.ready  = adv[0];
    assign rows.valid   = v_reg[NST-1];
    assign rows.payload = row_reg;
    assign keep = (boxes.payload.index_total != '0) && (boxes.payload.vertex_total != '0);

    always_comb
    begin
        crd_next[0][0] = CW'(boxes.payload.local_min_x);
        crd_next[0][1] = CW'(boxes.payload.local_max_x);
        crd_next[1][0] = -(CW'(boxes.payload.local_max_y));
        crd_next[1][1] = -(CW'(boxes.payload.local_min_y));
        crd_next[2][0] = CW'(boxes.payload.local_min_z);
        crd_next[2][1] = CW'(boxes.payload.local_max_z);
    end

    always_comb
    begin
        for (int r = 0; r < tbb_pkg::NUM_ROWS; r++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                for (int s = 0; s < 2; s++)
                begin
                    prod_next[r][a][s] = $signed(matrix[r][a]) * crd_reg[a][s];
                end
            end
        end
    end

    always_comb
    begin
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] shifted;
        sum     = '0;
        shifted = '0;
        for (int k = 0; k < tbb_pkg::NUM_CORNERS; k++)
        begin
            for (int r = 0; r < tbb_pkg::NUM_ROWS; r++)
            begin
                sum = SW'(prod_reg[r][0][k[0]]) + SW'(prod_reg[r][1][k[1]])
                    + SW'(prod_reg[r][2][k[2]]);
                shifted = sum >>> FRAC_BITS;
                row_next[k][r] = shifted[RWD-1:0] + RWD'($signed(matrix[r][3]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            crd_reg <= crd_next;
        end
        if (adv[1])
        begin
            prod_reg <= prod_next;
        end
        if (adv[2])
        begin
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= boxes.valid && keep;
            end
            for (int s = 1; s < NST; s++)
            begin
                if (adv[s])
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

endmodule

### hw/rtl/tbb_div.sv
// Perspective divide of 24 corner components, one restoring step per quotient-bit stage.
// Depends on tbb_pkg and tbb_if.
module tbb_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic  clk,
    input  logic  rst_n,
    tbb_if.sink   rows,
    tbb_if.source points
);

    localparam int QW  = tbb_pkg::COORD_W;
    localparam int WW  = tbb_pkg::ROW_W;
    localparam int RW  = WW + FRAC_BITS;
    localparam int NC  = tbb_pkg::NUM_CORNERS;
    localparam int NA  = tbb_pkg::NUM_AXES;
    localparam int NST = QW + 3;

    logic [NST-1:0] v_reg;
    logic [NST:0]   adv;

    logic [WW-1:0] d_w_reg   [NC];
    logic [WW-1:0] d_w_next  [NC];
    logic          d_neg_reg  [NC][NA];
    logic          d_neg_next [NC][NA];
    logic [WW-1:0] d_mag_reg  [NC][NA];
    logic [WW-1:0] d_mag_next [NC][NA];

    logic [WW-1:0] st_w_reg    [QW+1][NC];
    logic [WW-1:0] st_w_next   [QW+1][NC];
    logic          st_neg_reg  [QW+1][NC][NA];
    logic          st_neg_next [QW+1][NC][NA];
    logic          st_ovf_reg  [QW+1][NC][NA];
    logic          st_ovf_next [QW+1][NC][NA];
    logic [RW-1:0] st_rem_reg  [QW+1][NC][NA];
    logic [RW-1:0] st_rem_next [QW+1][NC][NA];
    logic [QW-1:0] st_q_reg    [QW+1][NC][NA];
    logic [QW-1:0] st_q_next   [QW+1][NC][NA];

    tbb_pkg::points_t out_reg;
    tbb_pkg::points_t out_next;

    always_comb
    begin
        adv[NST] = points.ready;
        for (int s = NST - 1; s >= 0; s--)
        begin
            adv[s] = !v_reg[s] || adv[s+1];
        end
    end

    assign rows.ready     = adv[0];
    assign points.valid   = v_reg[NST-1];
    assign points.payload = out_reg;

    // clamp w to one LSB, split components into sign and magnitude
    always_comb
    begin
        for (int k = 0; k < NC; k++)
        begin
            d_w_next[k] = ($signed(rows.payload[k][tbb_pkg::NUM_ROWS-1]) > 0)
                        ? rows.payload[k][tbb_pkg::NUM_ROWS-1] : WW'(1);
            for (int a = 0; a < NA; a++)
            begin
                d_neg_next[k][a] = rows.payload[k][a][WW-1];
                d_mag_next[k][a] = d_neg_next[k][a] ? (-rows.payload[k][a])
                                                    : rows.payload[k][a];
            end
        end
    end

    always_comb
    begin
        int sh;
        sh = 0;
        for (int k = 0; k < NC; k++)
        begin
            st_w_next[0][k] = d_w_reg[k];
            for (int a = 0; a < NA; a++)
            begin
                st_neg_next[0][k][a] = d_neg_reg[k][a];
                st_ovf_next[0][k][a] = (d_mag_reg[k][a] >> (QW - FRAC_BITS)) >= d_w_reg[k];
                st_rem_next[0][k][a] = {d_mag_reg[k][a], {FRAC_BITS{1'b0}}};
                st_q_next[0][k][a]   = '0;
            end
        end
        for (int j = 1; j <= QW; j++)
        begin
            sh = QW - j;
            for (int k = 0; k < NC; k++)
            begin
                st_w_next[j][k] = st_w_reg[j-1][k];
                for (int a = 0; a < NA; a++)
                begin
                    st_neg_next[j][k][a] = st_neg_reg[j-1][k][a];
                    st_ovf_next[j][k][a] = st_ovf_reg[j-1][k][a];
                    if ((st_rem_reg[j-1][k][a] >> sh) >= RW'(st_w_reg[j-1][k]))
                    begin
                        st_rem_next[j][k][a] = st_rem_reg[j-1][k][a]
                                             - (RW'(st_w_reg[j-1][k]) << sh);
                        st_q_next[j][k][a]   = {st_q_reg[j-1][k][a][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        st_rem_next[j][k][a] = st_rem_reg[j-1][k][a];
                        st_q_next[j][k][a]   = {st_q_reg[j-1][k][a][QW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // saturate and restore sign
    always_comb
    begin
        logic [QW-1:0] q;
        logic [QW-1:0] lim;
        logic [QW-1:0] val;
        logic          neg;
        q   = '0;
        lim = '0;
        val = '0;
        neg = 1'b0;
        for (int k = 0; k < NC; k++)
        begin
            for (int a = 0; a < NA; a++)
            begin
                q   = st_q_reg[QW][k][a];
                neg = st_neg_reg[QW][k][a];
                lim = {neg, {(QW-1){!neg}}};
                val = (st_ovf_reg[QW][k][a] || (q > lim)) ? lim : q;
                out_next[k][a] = neg ? (-val) : val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            d_w_reg   <= d_w_next;
            d_neg_reg <= d_neg_next;
            d_mag_reg <= d_mag_next;
        end
        for (int j = 0; j <= QW; j++)
        begin
            if (adv[j+1])
            begin
                st_w_reg[j]   <= st_w_next[j];
                st_neg_reg[j] <= st_neg_next[j];
                st_ovf_reg[j] <= st_ovf_next[j];
                st_rem_reg[j] <= st_rem_next[j];
                st_q_reg[j]   <= st_q_next[j];
            end
        end
        if (adv[NST-1])
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= rows.valid;
            end
            for (int s = 1; s < NST; s++)
            begin
                if (adv[s])
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

endmodule

### hw/rtl/tbb_reduce.sv
// Min/max tree over the eight corners, center and output register.
// Depends on tbb_pkg and tbb_if.
module tbb_reduce (
    input  logic  clk,
    input  logic  rst_n,
    tbb_if.sink   points,
    tbb_if.source bounds
);

    localparam int NST = 4;
    localparam int CW  = tbb_pkg::COORD_W;
    localparam int NA  = tbb_pkg::NUM_AXES;

    logic [NST-1:0] v_reg;
    logic [NST:0]   adv;

    logic signed [CW-1:0] lo1_reg [NA][4];
    logic signed [CW-1:0] hi1_reg [NA][4];
    logic signed [CW-1:0] lo1_next [NA][4];
    logic signed [CW-1:0] hi1_next [NA][4];
    logic signed [CW-1:0] lo2_reg [NA][2];
    logic signed [CW-1:0] hi2_reg [NA][2];
    logic signed [CW-1:0] lo2_next [NA][2];
    logic signed [CW-1:0] hi2_next [NA][2];
    logic signed [CW-1:0] lo3_reg [NA];
    logic signed [CW-1:0] hi3_reg [NA];
    logic signed [CW-1:0] lo3_next [NA];
    logic signed [CW-1:0] hi3_next [NA];
    logic signed [CW-1:0] ctr [NA];

    tbb_pkg::bounds_t out_reg;
    tbb_pkg::bounds_t out_next;

    always_comb
    begin
        adv[NST] = bounds.ready;
        for (int s = NST - 1; s >= 0; s--)
        begin
            adv[s] = !v_reg[s] || adv[s+1];
        end
    end

    assign points.ready   = adv[0];
    assign bounds.valid   = v_reg[NST-1];
    assign bounds.payload = out_reg;

    always_comb
    begin
        logic signed [CW-1:0] pa;
        logic signed [CW-1:0] pb;
        pa = '0;
        pb = '0;
        for (int a = 0; a < NA; a++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                pa = $signed(points.payload[i][a]);
                pb = $signed(points.payload[i+4][a]);
                lo1_next[a][i] = (pb < pa) ? pb : pa;
                hi1_next[a][i] = (pb > pa) ? pb : pa;
            end
            for (int i = 0; i < 2; i++)
            begin
                lo2_next[a][i] = (lo1_reg[a][i+2] < lo1_reg[a][i]) ? lo1_reg[a][i+2]
                                                                   : lo1_reg[a][i];
                hi2_next[a][i] = (hi1_reg[a][i+2] > hi1_reg[a][i]) ? hi1_reg[a][i+2]
                                                                   : hi1_reg[a][i];
            end
            lo3_next[a] = (lo2_reg[a][1] < lo2_reg[a][0]) ? lo2_reg[a][1] : lo2_reg[a][0];
            hi3_next[a] = (hi2_reg[a][1] > hi2_reg[a][0]) ? hi2_reg[a][1] : hi2_reg[a][0];
        end
    end

    always_comb
    begin
        logic signed [CW:0] csum;
        csum = '0;
        for (int a = 0; a < NA; a++)
        begin
            csum   = (CW+1)'(lo3_reg[a]) + (CW+1)'(hi3_reg[a]);
            ctr[a] = csum[CW:1];
        end
        out_next.world_min_x = lo3_reg[0];
        out_next.world_min_y = lo3_reg[1];
        out_next.world_min_z = lo3_reg[2];
        out_next.world_max_x = hi3_reg[0];
        out_next.world_max_y = hi3_reg[1];
        out_next.world_max_z = hi3_reg[2];
        out_next.center_x    = ctr[0];
        out_next.center_y    = ctr[1];
        out_next.center_z    = ctr[2];
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            lo1_reg <= lo1_next;
            hi1_reg <= hi1_next;
        end
        if (adv[1])
        begin
            lo2_reg <= lo2_next;
            hi2_reg <= hi2_next;
        end
        if (adv[2])
        begin
            lo3_reg <= lo3_next;
            hi3_reg <= hi3_next;
        end
        if (adv[3])
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= points.valid;
            end
            for (int s = 1; s < NST; s++)
            begin
                if (adv[s])
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

endmodule

### hw/rtl/transformed_box_bounds.sv
// Top level of the transformed box bounds block: matrix registers and pipeline.
// Depends on tbb_pkg, tbb_if, tbb_xform, tbb_div and tbb_reduce.
//
// Takes one box per cycle when the output side keeps taking, and returns
// its world bounds after 3 transform stages, 35 divide stages and 4 reduce
// stages. Most of the stages are in the 24 parallel restoring dividers,
// which resolve one quotient bit per stage. Boxes with a zero index or vertex
// count are accepted and give no result. The matrix registers are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while no box
// is in flight, which the block itself does not enforce. Writes to an index past the last register are ignored.
module transformed_box_bounds #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tbb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tbb_pkg::CFG_W-1:0]       cfg_data,
    tbb_if.sink                             boxes,
    tbb_if.source                           bounds
);

    localparam int NCFG = tbb_pkg::NUM_CFG;
    localparam int CW   = tbb_pkg::COORD_W;

    tbb_pkg::cfg_word_t cfg_reg [NCFG];
    logic [NCFG-1:0]    cfg_sel;
    tbb_pkg::matrix_t   matrix;

    tbb_if #(.T(tbb_pkg::rows_t))   rows_ch ();
    tbb_if #(.T(tbb_pkg::points_t)) points_ch ();

    always_comb
    begin
        cfg_sel = '0;
        case (tbb_pkg::cfg_reg_e'(cfg_index))
            tbb_pkg::CFG_ROW0_LO: cfg_sel[0] = cfg_we;
            tbb_pkg::CFG_ROW0_HI: cfg_sel[1] = cfg_we;
            tbb_pkg::CFG_ROW1_LO: cfg_sel[2] = cfg_we;
            tbb_pkg::CFG_ROW1_HI: cfg_sel[3] = cfg_we;
            tbb_pkg::CFG_ROW2_LO: cfg_sel[4] = cfg_we;
            tbb_pkg::CFG_ROW2_HI: cfg_sel[5] = cfg_we;
            tbb_pkg::CFG_ROW3_LO: cfg_sel[6] = cfg_we;
            tbb_pkg::CFG_ROW3_HI: cfg_sel[7] = cfg_we;
            default:              cfg_sel    = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NCFG; i++)
            begin
                cfg_reg[i] <= tbb_pkg::CFG_RESET[i];
            end
        end
        else
        begin
            for (int i = 0; i < NCFG; i++)
            begin
                if (cfg_sel[i])
                begin
                    cfg_reg[i] <= cfg_data;
                end
            end
        end
    end

    for (genvar r = 0; r < tbb_pkg::NUM_ROWS; r++)
    begin : g_row
        for (genvar c = 0; c < tbb_pkg::NUM_ROWS; c++)
        begin : g_col
            assign matrix[r][c] = cfg_reg[r*2 + c/2][(c%2)*CW +: CW];
        end
    end

    tbb_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
        .clk    (clk),
        .rst_n  (rst_n),
        .matrix (matrix),
        .boxes  (boxes),
        .rows   (rows_ch.source)
    );

    tbb_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .rows   (rows_ch.sink),
        .points (points_ch.source)
    );

    tbb_reduce u_reduce (
        .clk    (clk),
        .rst_n  (rst_n),
        .points (points_ch.sink),
        .bounds (bounds)
    );

endmodule

### tb/transformed_box_bounds_test.sv
// Self-checking testbench for transformed_box_bounds: boxes go through matrix settings
// and the world bounds are predicted and compared. Depends on tbb_pkg, tbb_if and the RTL.
module transformed_box_bounds_test;

    timeunit 1ns;
    timeprecision 1ps;

    import tbb_pkg::*;

    localparam int FRAC = 16;
    localparam int BOX_LATENCY = 42;

    typedef logic signed [79:0] wide_t;

    class bounds_book;
        logic signed [31:0] mat [4][4];
        bounds_t            pending_q [$];
        int                 errors;
        int                 checked;
        int                 dropped;

        function new();
            for (int i = 0; i < NUM_CFG; i++)
                set_reg(i, CFG_RESET[i]);
            errors  = 0;
            checked = 0;
            dropped = 0;
        endfunction

        function void set_reg(int idx, cfg_word_t data);
            int r;
            r = idx / 2;
            if (idx >= NUM_CFG)
                return;
            if (idx % 2 == 0)
            begin
                mat[r][0] = data[31:0];
                mat[r][1] = data[63:32];
            end
            else
            begin
                mat[r][2] = data[31:0];
                mat[r][3] = data[63:32];
            end
        endfunction

        function wide_t row_dot(int r, wide_t x, wide_t y, wide_t z);
            wide_t e0, e1, e2, e3, acc;
            e0  = mat[r][0];
            e1  = mat[r][1];
            e2  = mat[r][2];
            e3  = mat[r][3];
            acc = (e3 <<< FRAC) + e0 * x + e1 * y + e2 * z;
            return acc >>> FRAC;
        endfunction

        function logic signed [31:0] scale_div(wide_t num, wide_t w);
            logic        neg;
            logic [79:0] mag, q, lim;
            neg = num < 0;
            mag = neg ? -num : num;
            lim = neg ? 80'h8000_0000 : 80'h7FFF_FFFF;
            q   = mag / w;
            if (q >= 80'h8000_0000)
                q = lim;
            else
                q = (mag << FRAC) / w;
            if (q > lim)
                q = lim;
            return neg ? -q[31:0] : q[31:0];
        endfunction

        function void note_box(box_t b);
            wide_t              xs [2], ys [2], zs [2], w;
            logic signed [31:0] p [3], lo [3], hi [3];
            logic signed [32:0] sum;
            bounds_t            res;
            if (b.index_total == 0 || b.vertex_total == 0)
            begin
                dropped++;
                return;
            end
            xs[0] = b.local_min_x;
            xs[1] = b.local_max_x;
            ys[0] = -wide_t'(b.local_max_y);
            ys[1] = -wide_t'(b.local_min_y);
            zs[0] = b.local_min_z;
            zs[1] = b.local_max_z;
            for (int k = 0; k < NUM_CORNERS; k++)
            begin
                w = row_dot(3, xs[k & 1], ys[(k >> 1) & 1], zs[(k >> 2) & 1]);
                if (w < 1)
                    w = 1;
                for (int a = 0; a < 3; a++)
                begin
                    p[a] = scale_div(row_dot(a, xs[k & 1], ys[(k >> 1) & 1],
                                             zs[(k >> 2) & 1]), w);
                    if (k == 0 || p[a] < lo[a])
                        lo[a] = p[a];
                    if (k == 0 || p[a] > hi[a])
                        hi[a] = p[a];
                end
            end
            res.world_min_x = lo[0];
            res.world_min_y = lo[1];
            res.world_min_z = lo[2];
            res.world_max_x = hi[0];
            res.world_max_y = hi[1];
            res.world_max_z = hi[2];
            sum = 33'(lo[0]) + 33'(hi[0]);
            res.center_x = 32'(sum >>> 1);
            sum = 33'(lo[1]) + 33'(hi[1]);
            res.center_y = 32'(sum >>> 1);
            sum = 33'(lo[2]) + 33'(hi[2]);
            res.center_z = 32'(sum >>> 1);
            pending_q.insert(pending_q.size(), res);
        endfunction

        function void cmp(string name, coord_t exp_v, coord_t act_v);
            if (exp_v !== act_v)
            begin
                $error("%s: expected %0d actual %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_bounds(bounds_t act);
            bounds_t e;
            if (pending_q.size() == 0)
            begin
                $error("unexpected bounds transfer");
                errors++;
                return;
            end
            e = pending_q.pop_front();
            checked++;
            cmp("world_min_x", e.world_min_x, act.world_min_x);
            cmp("world_min_y", e.world_min_y, act.world_min_y);
            cmp("world_min_z", e.world_min_z, act.world_min_z);
            cmp("world_max_x", e.world_max_x, act.world_max_x);
            cmp("world_max_y", e.world_max_y, act.world_max_y);
            cmp("world_max_z", e.world_max_z, act.world_max_z);
            cmp("center_x", e.center_x, act.center_x);
            cmp("center_y", e.center_y, act.center_y);
            cmp("center_z", e.center_z, act.center_z);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    cfg_word_t            cfg_data;

    tbb_if #(.T(box_t))    boxes_ch ();
    tbb_if #(.T(bounds_t)) bounds_ch ();

    bounds_book sb = new();
    int         burst_left;
    int         rx_cycle = 0;
    int         rx_mode = 0;
    int         boxes_sent;

    transformed_box_bounds #(.FRAC_BITS(FRAC)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .boxes     (boxes_ch),
        .bounds    (bounds_ch)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Receiver stall pattern: always ready, random, or mostly stalled.
    always @(negedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 300 == 0)
            rx_mode <= $urandom_range(0, 2);
        case (rx_mode)
            0:       bounds_ch.ready <= 1'b1;
            1:       bounds_ch.ready <= 1'($urandom_range(0, 1));
            default: bounds_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && bounds_ch.valid && bounds_ch.ready)
            sb.check_bounds(bounds_ch.payload);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, cfg_word_t data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(int'(idx), data);
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_box(box_t b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                boxes_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        boxes_ch.valid   <= 1'b1;
        boxes_ch.payload <= b;
        do
            @(posedge clk);
        while (!boxes_ch.ready);
        sb.note_box(b);
        boxes_sent++;
    endtask

    // Hold until every expected bounds transfer has arrived, then let the pipe empty.
    task automatic drain();
        @(negedge clk);
        boxes_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (BOX_LATENCY + 20) @(posedge clk);
    endtask

    function automatic coord_t pick_coord(int kind);
        case (kind)
            0:       return coord_t'($urandom_range(0, 1 << 19)) - (1 << 18);
            1:       return coord_t'($urandom);
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7FFF_FFFF;
                    2:       return 0;
                    default: return -1;
                endcase
            end
        endcase
    endfunction

    function automatic box_t rand_box();
        box_t   b;
        coord_t t;
        int     kind;
        kind = $urandom_range(0, 9);
        kind = (kind < 5) ? 0 : (kind < 8) ? 1 : 2;
        b.local_min_x = pick_coord(kind);
        b.local_min_y = pick_coord(kind);
        b.local_min_z = pick_coord(kind);
        b.local_max_x = pick_coord(kind);
        b.local_max_y = pick_coord(kind);
        b.local_max_z = pick_coord(kind);
        if ($urandom_range(0, 9) != 0)
        begin
            if (b.local_min_x > b.local_max_x)
            begin
                t = b.local_min_x; b.local_min_x = b.local_max_x; b.local_max_x = t;
            end
            if (b.local_min_y > b.local_max_y)
            begin
                t = b.local_min_y; b.local_min_y = b.local_max_y; b.local_max_y = t;
            end
            if (b.local_min_z > b.local_max_z)
            begin
                t = b.local_min_z; b.local_min_z = b.local_max_z; b.local_max_z = t;
            end
        end
        b.index_total  = ($urandom_range(0, 1)) ? $urandom : $urandom_range(1, 64);
        b.vertex_total = ($urandom_range(0, 1)) ? $urandom : $urandom_range(1, 64);
        if (b.index_total == 0)
            b.index_total = 1;
        if (b.vertex_total == 0)
            b.vertex_total = 1;
        case ($urandom_range(0, 19))
            0:       b.index_total = 0;
            1:       b.vertex_total = 0;
            2:       begin b.index_total = 0; b.vertex_total = 0; end
            default: ;
        endcase
        return b;
    endfunction

    function automatic box_t make_box(coord_t lo, coord_t hi, logic [31:0] n);
        box_t b;
        b.local_min_x  = lo;
        b.local_min_y  = lo;
        b.local_min_z  = lo;
        b.local_max_x  = hi;
        b.local_max_y  = hi;
        b.local_max_z  = hi;
        b.index_total  = n;
        b.vertex_total = n;
        return b;
    endfunction

    function automatic logic [31:0] small_elem();
        return $urandom_range(0, 1 << 19) - (1 << 18);
    endfunction

    task automatic random_boxes(int count);
        repeat (count) send_box(rand_box());
        drain();
    endtask

    initial
    begin
        box_t b;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        boxes_ch.valid   = 1'b0;
        boxes_ch.payload = '0;
        burst_left       = 0;
        boxes_sent       = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed boxes at the reset identity matrix.
        send_box(make_box(0, 0, 1));
        send_box(make_box(32'sh8000_0000, 32'sh7FFF_FFFF, 32'hFFFF_FFFF));
        send_box(make_box(32'sh7FFF_FFFF, 32'sh8000_0000, 3));
        send_box(make_box(32'sh8000_0000, 32'sh8000_0000, 5));
        send_box(make_box(-32'sh0001_0000, 32'sh0002_8000, 7));
        b = make_box(-100, 100, 9);
        b.index_total = 0;
        send_box(b);
        b = make_box(-100, 100, 9);
        b.vertex_total = 0;
        send_box(b);
        b = make_box(-5, 5, 0);
        send_box(b);
        b = make_box(32'sh8000_0000, 32'sh7FFF_FFFF, 1);
        b.local_min_y = 32'sh8000_0000;
        b.local_max_y = 32'sh8000_0000;
        send_box(b);
        send_box(make_box(5, -5, 2));
        random_boxes(90);

        // Zero w row: every corner falls back to one LSB, so large components saturate.
        write_reg(CFG_ROW3_LO, 64'h0);
        write_reg(CFG_ROW3_HI, 64'h0);
        end_writes();
        send_box(make_box(-1, 1, 1));
        send_box(make_box(0, 0, 1));
        send_box(make_box(32'sh8000_0000, 32'sh7FFF_FFFF, 1));
        random_boxes(60);

        // Negative w.
        write_reg(CFG_ROW3_HI, {32'hFFFF_0000, 32'h0});
        end_writes();
        random_boxes(40);

        // Small random matrices whose w row has a positive offset.
        repeat (3)
        begin
            write_reg(CFG_ROW0_LO, {small_elem(), small_elem()});
            write_reg(CFG_ROW0_HI, {small_elem(), small_elem()});
            write_reg(CFG_ROW1_LO, {small_elem(), small_elem()});
            write_reg(CFG_ROW1_HI, {small_elem(), small_elem()});
            write_reg(CFG_ROW2_LO, {small_elem(), small_elem()});
            write_reg(CFG_ROW2_HI, {small_elem(), small_elem()});
            write_reg(CFG_ROW3_LO, {32'($urandom_range(0, 4096)), 32'($urandom_range(0, 4096))});
            write_reg(CFG_ROW3_HI, {32'($urandom_range(1 << 14, 1 << 18)),
                                    32'($urandom_range(0, 4096))});
            end_writes();
            random_boxes(70);
        end

        // Fully random registers.
        for (int i = 0; i < NUM_CFG; i++)
            write_reg(CFG_IDX_W'(i), {$urandom, $urandom});
        end_writes();
        random_boxes(60);

        // Extreme matrices.
        for (int i = 0; i < NUM_CFG; i++)
            write_reg(CFG_IDX_W'(i), 64'h7FFF_FFFF_7FFF_FFFF);
        end_writes();
        random_boxes(30);
        for (int i = 0; i < NUM_CFG; i++)
            write_reg(CFG_IDX_W'(i), 64'h8000_0000_8000_0000);
        end_writes();
        random_boxes(30);

        // Back to identity; a write past the last register must be ignored.
        for (int i = 0; i < NUM_CFG; i++)
            write_reg(CFG_IDX_W'(i), CFG_RESET[i]);
        write_reg(CFG_IDX_W'($urandom_range(NUM_CFG, (1 << CFG_IDX_W) - 1)), {$urandom, $urandom});
        end_writes();
        random_boxes(80);

        $display("Sent %0d boxes over ten matrix settings: %0d dropped, %0d bounds checked.",
                 boxes_sent, sb.dropped, sb.checked);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/tbb_pkg.sv
hw/rtl/tbb_if.sv
hw/rtl/tbb_xform.sv
hw/rtl/tbb_div.sv
hw/rtl/tbb_reduce.sv
hw/rtl/transformed_box_bounds.sv
tb/transformed_box_bounds_test.sv
